// ----- rtl/core/heap_sorter_macros.svh -----
// assertion macros for the heap sorter
`ifndef HEAP_SORTER_MACROS_SVH
`define HEAP_SORTER_MACROS_SVH

`ifndef ASSERT_OFF
`define HS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HS_ASSERT(label, clk, rst_n, prop, msg)
`define HS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ----- rtl/core/hs_pkg.sv -----
package hs_pkg;

    localparam int unsigned KEY_W      = 32;
    localparam int unsigned ADDR_W_MAX = 10;

    typedef struct packed {
        logic signed [KEY_W-1:0] value;
        logic                    last;
    } hs_item_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] sorted_value;
        logic                    last_out;
        logic                    overflow;
    } hs_result_t;

    typedef struct packed {
        logic go;
        logic desc;
        logic ovf;
    } hs_cmd_t;

    typedef struct packed {
        logic                    wr_en;
        logic [ADDR_W_MAX-1:0]   wr_addr;
        logic signed [KEY_W-1:0] wr_data;
        logic                    rd_en;
        logic [ADDR_W_MAX-1:0]   rd_addr;
    } hs_mem_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BUILD,
        ST_HOLD,
        ST_EXTRACT,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_CHK,
        ST_LEFT,
        ST_RIGHT,
        ST_DEC,
        ST_EMIT
    } hs_state_t;

    // heap is always a max heap on this rank
    function automatic logic [KEY_W-1:0] hs_rank(input logic [KEY_W-1:0] v, input logic desc);
        logic [KEY_W-1:0] r;
        r = v ^ {1'b1, {(KEY_W-1){1'b0}}};
        return desc ? ~r : r;
    endfunction

endpackage

// ----- rtl/core/hs_ram.sv -----
module hs_ram #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                        clk,
    input  hs_pkg::hs_mem_req_t         req,
    output logic signed [hs_pkg::KEY_W-1:0] rdata
);
    import hs_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);

    logic signed [KEY_W-1:0] mem [DEPTH];
    logic signed [KEY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.rd_addr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/hs_engine.sv -----
module hs_engine #(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  hs_pkg::hs_cmd_t                      cmd,
    input  logic [$clog2(MAX_ITEMS+1)-1:0]       len,
    input  logic signed [hs_pkg::KEY_W-1:0]      rdata,
    output hs_pkg::hs_mem_req_t                  req,
    output logic                                 busy,
    output logic                                 strobe,
    output hs_pkg::hs_result_t                   result
);
    import hs_pkg::*;

    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

    hs_state_t state_reg, state_next;

    logic                    build_reg, build_next;
    logic                    desc_reg, desc_next;
    logic                    ovf_reg, ovf_next;
    logic [CW-1:0]           len_reg, len_next;
    logic [CW-1:0]           i_reg, i_next;
    logic [CW-1:0]           k_reg, k_next;
    logic [CW-1:0]           sift_len_reg, sift_len_next;
    logic [CW-1:0]           best_idx_reg, best_idx_next;
    logic [CW-1:0]           j_reg, j_next;
    logic signed [KEY_W-1:0] hold_reg, hold_next;
    logic signed [KEY_W-1:0] best_reg, best_next;
    logic                    strobe_reg, strobe_next;
    logic                    last_reg, last_next;

    logic [CW:0]             child;
    logic                    child_out;
    logic                    has_right;
    logic                    right_wins;
    logic                    hold_stays;
    logic                    emit_end;

    assign child      = {k_reg, 1'b0};
    assign child_out  = child > {1'b0, sift_len_reg};
    assign has_right  = child < {1'b0, sift_len_reg};
    assign right_wins = hs_rank(rdata, desc_reg) > hs_rank(best_reg, desc_reg);
    assign hold_stays = hs_rank(best_reg, desc_reg) <= hs_rank(hold_reg, desc_reg);
    assign emit_end   = j_reg == (len_reg - CW'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.go)
                begin
                    state_next = ST_BUILD;
                end
            end
            ST_BUILD:    state_next = (i_reg != '0) ? ST_HOLD : ST_EXTRACT;
            ST_HOLD:     state_next = ST_CHK;
            ST_EXTRACT:  state_next = (i_reg > CW'(1)) ? ST_SWAP_A : ST_EMIT;
            ST_SWAP_A:   state_next = ST_SWAP_B;
            ST_SWAP_B:   state_next = ST_CHK;
            ST_CHK:
            begin
                if (child_out)
                begin
                    state_next = build_reg ? ST_BUILD : ST_EXTRACT;
                end
                else
                begin
                    state_next = ST_LEFT;
                end
            end
            ST_LEFT:     state_next = has_right ? ST_RIGHT : ST_DEC;
            ST_RIGHT:    state_next = ST_DEC;
            ST_DEC:
            begin
                if (hold_stays)
                begin
                    state_next = build_reg ? ST_BUILD : ST_EXTRACT;
                end
                else
                begin
                    state_next = ST_CHK;
                end
            end
            ST_EMIT:     state_next = emit_end ? ST_IDLE : ST_EMIT;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath registers
    always_comb
    begin
        build_next    = build_reg;
        desc_next     = desc_reg;
        ovf_next      = ovf_reg;
        len_next      = len_reg;
        i_next        = i_reg;
        k_next        = k_reg;
        sift_len_next = sift_len_reg;
        best_idx_next = best_idx_reg;
        j_next        = j_reg;
        hold_next     = hold_reg;
        best_next     = best_reg;
        strobe_next   = 1'b0;
        last_next     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.go)
                begin
                    len_next   = len;
                    desc_next  = cmd.desc;
                    ovf_next   = cmd.ovf;
                    i_next     = len >> 1;
                    build_next = 1'b1;
                end
            end
            ST_BUILD:
            begin
                if (i_reg != '0)
                begin
                    k_next        = i_reg;
                    sift_len_next = len_reg;
                end
                else
                begin
                    i_next     = len_reg;
                    build_next = 1'b0;
                end
            end
            ST_HOLD:     hold_next = rdata;
            ST_EXTRACT:  j_next = '0;
            ST_SWAP_A:   hold_next = rdata;
            ST_SWAP_B:
            begin
                k_next        = CW'(1);
                sift_len_next = i_reg - CW'(1);
            end
            ST_CHK:
            begin
                if (child_out)
                begin
                    i_next = i_reg - CW'(1);
                end
            end
            ST_LEFT:
            begin
                best_next     = rdata;
                best_idx_next = child[CW-1:0];
            end
            ST_RIGHT:
            begin
                if (right_wins)
                begin
                    best_next     = rdata;
                    best_idx_next = best_idx_reg + CW'(1);
                end
            end
            ST_DEC:
            begin
                if (hold_stays)
                begin
                    i_next = i_reg - CW'(1);
                end
                else
                begin
                    k_next = best_idx_reg;
                end
            end
            ST_EMIT:
            begin
                j_next      = j_reg + CW'(1);
                strobe_next = 1'b1;
                last_next   = emit_end;
            end
            default:
            begin
                build_next = build_reg;
            end
        endcase
    end

    // memory requests; reads and writes never meet on one entry in one cycle
    always_comb
    begin
        req         = '0;
        busy        = state_reg != ST_IDLE;
        case (state_reg)
            ST_BUILD:
            begin
                req.rd_en   = i_reg != '0;
                req.rd_addr = ADDR_W_MAX'(i_reg - CW'(1));
            end
            ST_EXTRACT:
            begin
                req.rd_en   = i_reg > CW'(1);
                req.rd_addr = ADDR_W_MAX'(i_reg - CW'(1));
            end
            ST_SWAP_A:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = '0;
            end
            ST_SWAP_B:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = ADDR_W_MAX'(i_reg - CW'(1));
                req.wr_data = rdata;
            end
            ST_CHK:
            begin
                req.wr_en   = child_out;
                req.wr_addr = ADDR_W_MAX'(k_reg - CW'(1));
                req.wr_data = hold_reg;
                req.rd_en   = !child_out;
                req.rd_addr = ADDR_W_MAX'(child - (CW+1)'(1));
            end
            ST_LEFT:
            begin
                req.rd_en   = has_right;
                req.rd_addr = ADDR_W_MAX'(child);
            end
            ST_DEC:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = ADDR_W_MAX'(k_reg - CW'(1));
                req.wr_data = hold_stays ? hold_reg : best_reg;
            end
            ST_EMIT:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = ADDR_W_MAX'(j_reg);
            end
            default:
            begin
                req.rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            build_reg  <= 1'b0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            build_reg  <= build_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
            ovf_reg    <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg     <= desc_next;
        len_reg      <= len_next;
        i_reg        <= i_next;
        k_reg        <= k_next;
        sift_len_reg <= sift_len_next;
        best_idx_reg <= best_idx_next;
        j_reg        <= j_next;
        hold_reg     <= hold_next;
        best_reg     <= best_next;
    end

    assign strobe              = strobe_reg;
    assign result.sorted_value = rdata;
    assign result.last_out     = last_reg;
    assign result.overflow     = ovf_reg;

endmodule

// ----- rtl/core/heap_sorter.sv -----
// heap sorter: collects signed 32-bit keys, then emits them sorted
// input: a key transfer happens on a clock edge with start high and busy low;
//   item.last closes the set and starts the sort. keys are loaded one per
//   cycle; keys past MAX_ITEMS are dropped and flag overflow on every result
// configuration: cfg_data is the order bit (0 ascending, 1 descending),
//   written when cfg_valid is high; cfg_ready is always high. write only
//   while busy is low; the bit is taken when the closing key arrives
// output: one result per stored key, each on the result ports for a single
//   cycle with strobe high; last_out marks the final one. the receiver
//   cannot stall
// timing: busy rises the cycle after the closing key and falls as the final
//   result is shown. the sort runs n/2 + n - 1 sift passes; each heap level
//   takes up to two child reads through the one memory read port, a compare
//   and one write back, and each pass first reads its node or swaps root and
//   last key; then the results stream out of the memory in order
// reset: clears the key count, overflow flag and order bit; the key memory
//   needs no clearing as only keys of the current set are read
`include "heap_sorter_macros.svh"

module heap_sorter #(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  hs_pkg::hs_item_t   item,
    output logic               strobe,
    output hs_pkg::hs_result_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data
);
    import hs_pkg::*;

    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

    logic [CW-1:0]           count_reg, count_next;
    logic                    dropped_reg, dropped_next;
    logic                    desc_reg;
    logic                    accept;
    logic                    full;
    logic [CW-1:0]           run_len;
    hs_cmd_t                 cmd;
    hs_mem_req_t             eng_req;
    hs_mem_req_t             mem_req;
    logic signed [KEY_W-1:0] rdata;

    assign accept    = start && !busy;
    assign full      = count_reg == CW'(MAX_ITEMS);
    assign run_len   = full ? count_reg : count_reg + CW'(1);
    assign cfg_ready = 1'b1;

    assign cmd.go   = accept && item.last;
    assign cmd.desc = desc_reg;
    assign cmd.ovf  = dropped_reg || full;

    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        if (cmd.go)
        begin
            count_next   = '0;
            dropped_next = 1'b0;
        end
        else if (accept)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
    end

    // loading owns the write port while the engine is idle
    always_comb
    begin
        mem_req = eng_req;
        if (accept && !full)
        begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = ADDR_W_MAX'(count_reg);
            mem_req.wr_data = item.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            desc_reg    <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            if (cfg_valid && cfg_ready)
            begin
                desc_reg <= cfg_data;
            end
        end
    end

    hs_ram #(
        .DEPTH (MAX_ITEMS)
    ) u_ram (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    hs_engine #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .len    (run_len),
        .rdata  (rdata),
        .req    (eng_req),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    `HS_ASSERT(a_count_range, clk, rst_n, count_reg <= CW'(MAX_ITEMS), "key count past capacity")
    `HS_ASSERT(a_close_starts, clk, rst_n, cmd.go |=> busy, "closing key did not start the sort")
    `HS_ASSERT(a_final_alone, clk, rst_n, strobe && result.last_out |=> !strobe, "result after final")
    `HS_ASSERT(a_strobe_busy, clk, rst_n, strobe |-> $past(busy), "result without a sort")
    `HS_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !busy && !strobe, "not idle after reset")

endmodule
